### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// ASSERT_RST checks a property on every rising clock edge outside reset.
// ASSERT_CLK checks a property on every rising clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define ASSERT_RST(label, prop, msg)

`define ASSERT_CLK(label, prop, msg)

`endif

`endif

### rtl/prf_pkg.sv
package prf_pkg;

  // Field widths
  localparam int COORD_W    = 31;
  localparam int DELTA_W    = 32;
  localparam int OWNER_W    = 10;
  localparam int FORCE_W    = 48;
  localparam int STRENGTH_W = 24;
  localparam int CUTOFF_W   = 48;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  // Parameter defaults
  localparam int COORD_FRAC_BITS_DEF = 22;
  localparam int OWNER_BITS_DEF      = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 1'b1;

  // Register resets
  localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 24'd901120;
  localparam logic [CUTOFF_W-1:0]   CUTOFF_RESET   = 48'd22164764633267;

  // Arithmetic constants
  localparam int           U_FRAC    = 20;
  localparam int           U_W       = 63;
  localparam int           MAG_W     = 47;
  localparam int           DIV_STEPS = 65;
  localparam int           STR_SHIFT = 16;
  localparam logic [63:0]  POW_CAP   = 64'h4000_0000_0000_0000;
  localparam logic [63:0]  FORCE_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0]  RSQ_FLOOR = 64'd17;
  localparam logic [5:0]   STR_MUL   = 6'd48;

  // Per-item control and deltas that ride along the pipeline
  typedef struct packed {
    logic               valid;
    logic               applied;
    logic               sx;
    logic               sy;
    logic [DELTA_W-1:0] ax;
    logic [DELTA_W-1:0] ay;
  } prf_side_t;

  // One stage of the reciprocal divider
  typedef struct packed {
    prf_side_t            side;
    logic [CUTOFF_W:0]    rem;
    logic [CUTOFF_W-1:0]  dvs;
    logic [DIV_STEPS-1:0] quo;
  } prf_div_t;

endpackage

### rtl/prf_mulsat.sv
module prf_mulsat
  import prf_pkg::*;
#(
  parameter int          SHIFT = U_FRAC,
  parameter int          OUT_W = U_W,
  parameter logic [63:0] CAP   = POW_CAP
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [63:0]      a_i,
  input  logic [63:0]      b_i,
  output logic [OUT_W-1:0] res_o,
  output logic             sat_o
);

  logic [63:0]      ll_q, lh_q, hl_q, hh_q;
  logic [127:0]     prod;
  logic [127:0]     shifted;
  logic             sat_d;
  logic [OUT_W-1:0] res_d;

  // Form the 32x32 partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_i[31:0]  * b_i[31:0];
      lh_q <= a_i[31:0]  * b_i[63:32];
      hl_q <= a_i[63:32] * b_i[31:0];
      hh_q <= a_i[63:32] * b_i[63:32];
    end
  end

  // Sum, scale down and limit to the cap
  always_comb begin
    prod    = {64'd0, ll_q} + ({64'd0, lh_q} << 32) + ({64'd0, hl_q} << 32) + {hh_q, 64'd0};
    shifted = prod >> SHIFT;
    sat_d   = shifted > {64'd0, CAP};
    res_d   = sat_d ? CAP[OUT_W-1:0] : shifted[OUT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
      sat_o <= sat_d;
    end
  end

endmodule

### rtl/pair_repulsion_force.sv
// Repulsive pair force between two beads, one pair per clock while the output is not stalled.
// Input channel: in_valid_i / in_stall_o with both bead positions (signed
// fixed point, COORD_FRAC_BITS fraction bits) and the owning swimmer ids.
// Output channel: out_valid_o / out_stall_i with force_x_o, force_y_o
// (signed Q31.16) on the first bead, applied_o and clipped_o.
// An item moves on a rising edge with valid high and stall low.
// One item per cycle sustained while the output is not stalled.
// The pipeline is two input stages, the 65-step restoring divider that forms
// 1/r^2 (one quotient bit per stage), five two-stage multiplies in series,
// the sign split of the potential term and the output register.
// Configuration: cfg_we_i with cfg_idx_i selects strength (0) or cutoff
// (1); cfg_data_i low bits are taken. Write only while the block is empty.
// Reset clears all valid bits and loads default strength and cutoff.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall_o rises in the same cycle; nothing is lost or repeated.
`include "assert_macros.svh"

module pair_repulsion_force
  import prf_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int OWNER_BITS      = OWNER_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_W-1:0]    first_x_i,
  input  logic signed [COORD_W-1:0]    first_y_i,
  input  logic signed [COORD_W-1:0]    second_x_i,
  input  logic signed [COORD_W-1:0]    second_y_i,
  input  logic [OWNER_W-1:0]           first_owner_i,
  input  logic [OWNER_W-1:0]           second_owner_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [FORCE_W-1:0]    force_x_o,
  output logic signed [FORCE_W-1:0]    force_y_o,
  output logic                         applied_o,
  output logic                         clipped_o
);

  localparam int OWN_CMP = (OWNER_BITS < OWNER_W) ? OWNER_BITS : OWNER_W;
  localparam bit Q_RIGHT = (2 * COORD_FRAC_BITS >= 44);
  localparam int RSH     = Q_RIGHT ? 2 * COORD_FRAC_BITS - 44 : 0;
  localparam int LSH     = Q_RIGHT ? 0 : 44 - 2 * COORD_FRAC_BITS;
  localparam int F_SHIFT = COORD_FRAC_BITS + 4;

  logic adv;

  logic [STRENGTH_W-1:0] strength_q;
  logic [CUTOFF_W-1:0]   cutoff_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= STRENGTH_RESET;
      cutoff_q   <= CUTOFF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STRENGTH: strength_q <= cfg_data_i[STRENGTH_W-1:0];
        REG_CUTOFF:   cutoff_q   <= cfg_data_i[CUTOFF_W-1:0];
        default:      ;
      endcase
    end
  end

  // Advance the whole pipeline unless a finished item waits on a stall
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Stage 0: deltas, magnitudes and owner test
  logic signed [DELTA_W-1:0] dx, dy;
  prf_side_t p0_d, p0_q;

  always_comb begin
    dx = {first_x_i[COORD_W-1], first_x_i} - {second_x_i[COORD_W-1], second_x_i};
    dy = {first_y_i[COORD_W-1], first_y_i} - {second_y_i[COORD_W-1], second_y_i};
    p0_d.valid   = in_valid_i;
    p0_d.applied = first_owner_i[OWN_CMP-1:0] != second_owner_i[OWN_CMP-1:0];
    p0_d.sx      = dx[DELTA_W-1];
    p0_d.sy      = dy[DELTA_W-1];
    p0_d.ax      = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
    p0_d.ay      = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q <= '0;
    end else if (adv) begin
      p0_q <= p0_d;
    end
  end

  // Stage 1: squares
  prf_side_t   p1_q;
  logic [63:0] sqx_q, sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
    end else if (adv) begin
      p1_q <= p0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q <= p0_q.ax * p0_q.ax;
      sqy_q <= p0_q.ay * p0_q.ay;
    end
  end

  // Stage 2: r^2 in Q.44 and range test
  logic [63:0] r2, rsq;
  prf_side_t   p2_d;
  prf_div_t    dv_in;
  prf_div_t    dv_q [DIV_STEPS];

  always_comb begin
    r2 = sqx_q + sqy_q;
    if (Q_RIGHT) begin
      rsq = r2 >> RSH;
    end else if (r2 > ({64{1'b1}} >> LSH)) begin
      rsq = {64{1'b1}};
    end else begin
      rsq = r2 << LSH;
    end
    p2_d         = p1_q;
    p2_d.applied = p1_q.applied && (rsq < {16'd0, cutoff_q}) && (rsq > RSQ_FLOOR);
    dv_in.side   = p2_d;
    dv_in.rem    = '0;
    dv_in.dvs    = rsq[CUTOFF_W-1:0];
    dv_in.quo    = '0;
  end

  // Divider: one quotient bit of 2^64 / r^2 per stage
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    prf_div_t          src, dv_d;
    logic [CUTOFF_W:0] rsh;
    logic              ge;

    always_comb begin
      src       = (i == 0) ? dv_in : dv_q[(i == 0) ? 0 : i - 1];
      rsh       = {src.rem[CUTOFF_W-1:0], (i == 0)};
      ge        = rsh >= {1'b0, src.dvs};
      dv_d      = src;
      dv_d.rem  = ge ? rsh - {1'b0, src.dvs} : rsh;
      dv_d.quo  = {src.quo[DIV_STEPS-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i] <= '0;
      end else if (adv) begin
        dv_q[i] <= dv_d;
      end
    end
  end

  // Side-data delay lines alongside the multipliers
  prf_side_t side_a_q [2];
  prf_side_t side_b_q [2];
  prf_side_t side_c_q [2];
  prf_side_t side_d_q;
  prf_side_t side_e_q [2];
  prf_side_t side_f_q [2];
  logic [U_W-1:0] ua_q  [2];
  logic [U_W-1:0] u4c_q [2];
  logic           neg_d_q;
  logic           neg_e_q [2];
  logic           neg_f_q [2];
  logic [U_W-1:0] dmag_d_q;

  logic [U_W-1:0]   u, u2, u3, u4, u7, g, half;
  logic [MAG_W-1:0] magx, magy;
  logic             s_u2, s_u3, s_u4, s_u7, s_g, satx, saty;

  assign u = dv_q[DIV_STEPS-1].quo[U_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_a_q <= '{default: '0};
      side_b_q <= '{default: '0};
      side_c_q <= '{default: '0};
      side_d_q <= '0;
      side_e_q <= '{default: '0};
      side_f_q <= '{default: '0};
    end else if (adv) begin
      side_a_q[0] <= dv_q[DIV_STEPS-1].side;
      side_a_q[1] <= side_a_q[0];
      side_b_q[0] <= side_a_q[1];
      side_b_q[1] <= side_b_q[0];
      side_c_q[0] <= side_b_q[1];
      side_c_q[1] <= side_c_q[0];
      side_d_q    <= side_c_q[1];
      side_e_q[0] <= side_d_q;
      side_e_q[1] <= side_e_q[0];
      side_f_q[0] <= side_e_q[1];
      side_f_q[1] <= side_f_q[0];
    end
  end

  // Payload delays and the sign split of u^7 - u^4/2
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ua_q[0]    <= u;
      ua_q[1]    <= ua_q[0];
      u4c_q[0]   <= u4;
      u4c_q[1]   <= u4c_q[0];
      neg_d_q    <= u7 < half;
      dmag_d_q   <= (u7 < half) ? half - u7 : u7 - half;
      neg_e_q[0] <= neg_d_q;
      neg_e_q[1] <= neg_e_q[0];
      neg_f_q[0] <= neg_e_q[1];
      neg_f_q[1] <= neg_f_q[0];
    end
  end

  assign half = u4c_q[1] >> 1;

  prf_mulsat #(.SHIFT(U_FRAC), .OUT_W(U_W), .CAP(POW_CAP)) u_mul_u2 (
    .clk_i, .en_i(adv), .a_i(64'(u)), .b_i(64'(u)), .res_o(u2), .sat_o(s_u2)
  );

  prf_mulsat #(.SHIFT(U_FRAC), .OUT_W(U_W), .CAP(POW_CAP)) u_mul_u3 (
    .clk_i, .en_i(adv), .a_i(64'(u2)), .b_i(64'(ua_q[1])), .res_o(u3), .sat_o(s_u3)
  );

  prf_mulsat #(.SHIFT(U_FRAC), .OUT_W(U_W), .CAP(POW_CAP)) u_mul_u4 (
    .clk_i, .en_i(adv), .a_i(64'(u2)), .b_i(64'(u2)), .res_o(u4), .sat_o(s_u4)
  );

  prf_mulsat #(.SHIFT(U_FRAC), .OUT_W(U_W), .CAP(POW_CAP)) u_mul_u7 (
    .clk_i, .en_i(adv), .a_i(64'(u3)), .b_i(64'(u4)), .res_o(u7), .sat_o(s_u7)
  );

  prf_mulsat #(.SHIFT(STR_SHIFT), .OUT_W(U_W), .CAP(POW_CAP)) u_mul_g (
    .clk_i, .en_i(adv), .a_i(64'(dmag_d_q)), .b_i(64'(strength_q) * 64'(STR_MUL)),
    .res_o(g), .sat_o(s_g)
  );

  prf_mulsat #(.SHIFT(F_SHIFT), .OUT_W(MAG_W), .CAP(FORCE_MAX)) u_mul_fx (
    .clk_i, .en_i(adv), .a_i(64'(g)), .b_i(64'(side_e_q[1].ax)), .res_o(magx), .sat_o(satx)
  );

  prf_mulsat #(.SHIFT(F_SHIFT), .OUT_W(MAG_W), .CAP(FORCE_MAX)) u_mul_fy (
    .clk_i, .en_i(adv), .a_i(64'(g)), .b_i(64'(side_e_q[1].ay)), .res_o(magy), .sat_o(saty)
  );

  // Output register: apply signs, zero excluded pairs
  logic [FORCE_W-1:0] fx_d, fy_d;
  logic               app_f;

  always_comb begin
    app_f = side_f_q[1].applied;
    fx_d  = (neg_f_q[1] ^ side_f_q[1].sx) ? -{1'b0, magx} : {1'b0, magx};
    fy_d  = (neg_f_q[1] ^ side_f_q[1].sy) ? -{1'b0, magy} : {1'b0, magy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= side_f_q[1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      force_x_o <= app_f ? fx_d : '0;
      force_y_o <= app_f ? fy_d : '0;
      applied_o <= app_f;
      clipped_o <= app_f && (satx || saty);
    end
  end

  `ASSERT_RST(a_excluded_zero, out_valid_o && !applied_o |-> force_x_o == '0 && force_y_o == '0 && !clipped_o, "excluded pair gives nonzero force")
  `ASSERT_RST(a_div_rem, dv_q[DIV_STEPS-1].side.valid && dv_q[DIV_STEPS-1].side.applied |-> dv_q[DIV_STEPS-1].rem < {1'b0, dv_q[DIV_STEPS-1].dvs}, "divider remainder not below divisor")
  `ASSERT_RST(a_hold_on_stall, in_stall_o |=> $stable(side_f_q[1]) && $stable(p0_q), "pipeline moved while stalled")
  `ASSERT_CLK(a_stall_cause, in_stall_o |-> out_valid_o, "input stalled with empty output")

endmodule
